// ----- hw/rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/slt_pkg.sv -----
// -----------------------------------------------------------------------------
// Shell line tokenizer package
// Event, token and lexer mode codes, character constants and result type.
// -----------------------------------------------------------------------------
package slt_pkg;

  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_LINE = 2'd2;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_QUOTED = 2'd1;
  localparam logic [1:0] KIND_OP     = 2'd2;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_QUOTE = 2'd2;
  localparam logic [1:0] MODE_OP    = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] out_byte;
    logic [1:0] token_kind;
    logic [7:0] token_count;
    logic       last_of_run;
  } result_t;

endpackage

// ----- hw/rtl/shell_line_tokenizer.sv -----
// -----------------------------------------------------------------------------
// Shell line tokenizer
// Splits a command line, one byte per transaction, into token bytes,
// token-end marks and a line-end event with the token count.
//
//   channel  direction  handshake                  payload
//   line     in         line_valid / line_ready    line_byte
//   event    out        event_valid / event_ready  event_kind, out_byte,
//                                                  token_kind, token_count,
//                                                  last_of_run
//
// A byte is lexed in the cycle it is taken; its zero to two results enter a
// four-entry result queue and leave one per cycle while event_ready is high,
// from the next cycle on. Sustained rate: one byte per cycle while each byte
// gives at most one result and event_ready stays high. line_ready is high
// while the queue, after this cycle's read, holds at most one entry.
// Synchronous reset empties the queue and idles the lexer.
// -----------------------------------------------------------------------------
module shell_line_tokenizer #(
  parameter int TOKEN_COUNT_MAX = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       line_valid,
  output logic       line_ready,
  input  logic [7:0] line_byte,
  output logic       event_valid,
  input  logic       event_ready,
  output logic [1:0] event_kind,
  output logic [7:0] out_byte,
  output logic [1:0] token_kind,
  output logic [7:0] token_count,
  output logic       last_of_run
);

  `include "assert_macros.svh"

  localparam logic [7:0] CNT_LIMIT =
    (TOKEN_COUNT_MAX < 255) ? 8'(TOKEN_COUNT_MAX) : 8'd255;

  logic [1:0] mode, mode_next;
  logic       quote_single, quote_single_next;
  logic [7:0] held_op, held_op_next;
  logic [7:0] tokens_done, tokens_done_next;

  slt_pkg::result_t fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [2:0] count_after_pop;

  slt_pkg::result_t res [3];
  logic [1:0] n_res;
  logic       do_idle;
  logic       b_space, b_op, b_quote;
  logic [7:0] quote_ch;
  logic       in_fire, out_fire;

  assign b_space = (line_byte == slt_pkg::CH_SPACE) ||
                   ((line_byte >= slt_pkg::CH_TAB) && (line_byte <= slt_pkg::CH_CR));
  assign b_op    = (line_byte == slt_pkg::CH_AMP) || (line_byte == slt_pkg::CH_PIPE) ||
                   (line_byte == slt_pkg::CH_LT)  || (line_byte == slt_pkg::CH_GT);
  assign b_quote = (line_byte == slt_pkg::CH_DQ) || (line_byte == slt_pkg::CH_SQ);
  assign quote_ch = quote_single ? slt_pkg::CH_SQ : slt_pkg::CH_DQ;

  assign out_fire        = event_valid && event_ready;
  assign count_after_pop = count - {2'b00, out_fire};
  assign line_ready      = (count_after_pop <= 3'd1);
  assign in_fire         = line_valid && line_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    n_res             = 2'd0;
    do_idle           = 1'b0;
    mode_next         = mode;
    quote_single_next = quote_single;
    held_op_next      = held_op;
    tokens_done_next  = tokens_done;

    if (line_byte == slt_pkg::CH_NUL) begin
      if (mode != slt_pkg::MODE_IDLE) begin
        if (tokens_done_next < CNT_LIMIT) begin
          tokens_done_next = tokens_done_next + 8'd1;
        end
        res[n_res].event_kind  = slt_pkg::EV_END;
        res[n_res].token_kind  = (mode == slt_pkg::MODE_WORD)  ? slt_pkg::KIND_WORD :
                                 (mode == slt_pkg::MODE_QUOTE) ? slt_pkg::KIND_QUOTED :
                                                                 slt_pkg::KIND_OP;
        res[n_res].token_count = tokens_done_next;
        n_res = n_res + 2'd1;
      end
      res[n_res].event_kind  = slt_pkg::EV_LINE;
      res[n_res].token_count = tokens_done_next;
      n_res = n_res + 2'd1;
      mode_next         = slt_pkg::MODE_IDLE;
      quote_single_next = 1'b0;
      held_op_next      = 8'd0;
      tokens_done_next  = 8'd0;
    end else begin
      case (mode)
        slt_pkg::MODE_WORD: begin
          if (b_space || b_op) begin
            if (tokens_done_next < CNT_LIMIT) begin
              tokens_done_next = tokens_done_next + 8'd1;
            end
            res[n_res].event_kind  = slt_pkg::EV_END;
            res[n_res].token_kind  = slt_pkg::KIND_WORD;
            res[n_res].token_count = tokens_done_next;
            n_res = n_res + 2'd1;
            mode_next    = slt_pkg::MODE_IDLE;
            held_op_next = 8'd0;
            do_idle      = 1'b1;
          end else begin
            res[n_res].event_kind  = slt_pkg::EV_BYTE;
            res[n_res].out_byte    = line_byte;
            res[n_res].token_kind  = slt_pkg::KIND_WORD;
            res[n_res].token_count = tokens_done_next;
            n_res = n_res + 2'd1;
          end
        end
        slt_pkg::MODE_QUOTE: begin
          if (line_byte == quote_ch) begin
            if (tokens_done_next < CNT_LIMIT) begin
              tokens_done_next = tokens_done_next + 8'd1;
            end
            res[n_res].event_kind  = slt_pkg::EV_END;
            res[n_res].token_kind  = slt_pkg::KIND_QUOTED;
            res[n_res].token_count = tokens_done_next;
            n_res = n_res + 2'd1;
            mode_next    = slt_pkg::MODE_IDLE;
            held_op_next = 8'd0;
          end else begin
            res[n_res].event_kind  = slt_pkg::EV_BYTE;
            res[n_res].out_byte    = line_byte;
            res[n_res].token_kind  = slt_pkg::KIND_QUOTED;
            res[n_res].token_count = tokens_done_next;
            n_res = n_res + 2'd1;
          end
        end
        slt_pkg::MODE_OP: begin
          if (line_byte == held_op) begin
            res[n_res].event_kind  = slt_pkg::EV_BYTE;
            res[n_res].out_byte    = line_byte;
            res[n_res].token_kind  = slt_pkg::KIND_OP;
            res[n_res].token_count = tokens_done_next;
            n_res = n_res + 2'd1;
          end else begin
            do_idle = 1'b1;
          end
          if (tokens_done_next < CNT_LIMIT) begin
            tokens_done_next = tokens_done_next + 8'd1;
          end
          res[n_res].event_kind  = slt_pkg::EV_END;
          res[n_res].token_kind  = slt_pkg::KIND_OP;
          res[n_res].token_count = tokens_done_next;
          n_res = n_res + 2'd1;
          mode_next    = slt_pkg::MODE_IDLE;
          held_op_next = 8'd0;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle && !b_space) begin
        if (b_quote) begin
          mode_next         = slt_pkg::MODE_QUOTE;
          quote_single_next = (line_byte == slt_pkg::CH_SQ);
        end else if (b_op) begin
          mode_next    = slt_pkg::MODE_OP;
          held_op_next = line_byte;
          res[n_res].event_kind  = slt_pkg::EV_BYTE;
          res[n_res].out_byte    = line_byte;
          res[n_res].token_kind  = slt_pkg::KIND_OP;
          res[n_res].token_count = tokens_done_next;
          n_res = n_res + 2'd1;
        end else begin
          mode_next = slt_pkg::MODE_WORD;
          res[n_res].event_kind  = slt_pkg::EV_BYTE;
          res[n_res].out_byte    = line_byte;
          res[n_res].token_kind  = slt_pkg::KIND_WORD;
          res[n_res].token_count = tokens_done_next;
          n_res = n_res + 2'd1;
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      res[i].last_of_run = (2'(i) == (n_res - 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= slt_pkg::MODE_IDLE;
      quote_single <= 1'b0;
      held_op      <= 8'd0;
      tokens_done  <= 8'd0;
      wr_ptr       <= 2'd0;
      rd_ptr       <= 2'd0;
      count        <= 3'd0;
    end else begin
      if (in_fire) begin
        mode         <= mode_next;
        quote_single <= quote_single_next;
        held_op      <= held_op_next;
        tokens_done  <= tokens_done_next;
        wr_ptr       <= wr_ptr + n_res;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_after_pop + (in_fire ? {1'b0, n_res} : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_res) begin
          fifo[wr_ptr + 2'(i)] <= res[i];
        end
      end
    end
  end

  assign event_valid = (count != 3'd0);
  assign event_kind  = fifo[rd_ptr].event_kind;
  assign out_byte    = fifo[rd_ptr].out_byte;
  assign token_kind  = fifo[rd_ptr].token_kind;
  assign token_count = fifo[rd_ptr].token_count;
  assign last_of_run = fifo[rd_ptr].last_of_run;

  `ASSERT_CLK(a_queue_bound, count <= 3'd4, "result queue over capacity")
  `ASSERT_CLK(a_line_clears,
    (in_fire && line_byte == slt_pkg::CH_NUL) |=>
      (mode == slt_pkg::MODE_IDLE && tokens_done == 8'd0),
    "lexer state not cleared after line end")
  `ASSERT_CLK(a_count_limit, tokens_done <= CNT_LIMIT, "token count above limit")
  `ASSERT_CLK(a_held_op, (mode == slt_pkg::MODE_OP) |-> (held_op != 8'd0),
    "operator mode without held operator")
  `ASSERT_CLK(a_event_code, event_valid |-> (event_kind != 2'd3),
    "undefined event code on output")

endmodule

// ----- tb/tb_shell_line_tokenizer.sv -----
// -----------------------------------------------------------------------------
// Shell line tokenizer testbench
// Feeds command lines byte by byte (directed lines, a full-rate burst, a long
// receiver hold-off, a drained pause, a token-count saturation line and random
// lines with noise) and checks every event transaction against a lexer model
// kept in the testbench, with random idle cycles on both channels.
// -----------------------------------------------------------------------------
module tb_shell_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOKEN_COUNT_MAX = 255;
  localparam int TOKEN_LIMIT     = (TOKEN_COUNT_MAX < 255) ? TOKEN_COUNT_MAX : 255;
  localparam int RANDOM_ITEMS    = 40;
  localparam int RX_HOLD_CYCLES  = 200;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_TAIL      = 16;
  localparam int SAT_PAIRS       = 131;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       line_valid = 1'b0;
  logic       line_ready;
  logic [7:0] line_byte = 8'h00;
  logic       event_valid;
  logic       event_ready = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] out_byte;
  logic [1:0] token_kind;
  logic [7:0] token_count;
  logic       last_of_run;

  shell_line_tokenizer #(
    .TOKEN_COUNT_MAX(TOKEN_COUNT_MAX)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_byte  (line_byte),
    .event_valid(event_valid),
    .event_ready(event_ready),
    .event_kind (event_kind),
    .out_byte   (out_byte),
    .token_kind (token_kind),
    .token_count(token_count),
    .last_of_run(last_of_run)
  );

  initial forever #6 clk = ~clk;

  logic [1:0]       lx_mode   = slt_pkg::MODE_IDLE;
  logic             lx_single = 1'b0;
  logic [7:0]       lx_held   = 8'h00;
  logic [7:0]       lx_count  = 8'h00;
  slt_pkg::result_t run_buf[3];
  int               run_len;
  slt_pkg::result_t event_q[$];
  slt_pkg::result_t exp_head;

  int errors     = 0;
  int bytes_sent = 0;
  int stuck      = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  function automatic bit is_blank(logic [7:0] b);
    return b == slt_pkg::CH_SPACE || (b >= slt_pkg::CH_TAB && b <= slt_pkg::CH_CR);
  endfunction

  function automatic bit is_oper(logic [7:0] b);
    return b == slt_pkg::CH_AMP || b == slt_pkg::CH_PIPE ||
           b == slt_pkg::CH_LT  || b == slt_pkg::CH_GT;
  endfunction

  function void emit(logic [1:0] ev, logic [7:0] b, logic [1:0] kind);
    run_buf[run_len].event_kind  = ev;
    run_buf[run_len].out_byte    = b;
    run_buf[run_len].token_kind  = kind;
    run_buf[run_len].token_count = lx_count;
    run_buf[run_len].last_of_run = 1'b0;
    run_len++;
  endfunction

  function void close_token(logic [1:0] kind);
    if (lx_count < TOKEN_LIMIT) lx_count++;
    emit(slt_pkg::EV_END, 8'h00, kind);
    lx_mode = slt_pkg::MODE_IDLE;
    lx_held = 8'h00;
  endfunction

  function void start_token(logic [7:0] b);
    if (is_blank(b)) return;
    if (b == slt_pkg::CH_DQ || b == slt_pkg::CH_SQ) begin
      lx_mode   = slt_pkg::MODE_QUOTE;
      lx_single = (b == slt_pkg::CH_SQ);
    end else if (is_oper(b)) begin
      lx_mode = slt_pkg::MODE_OP;
      lx_held = b;
      emit(slt_pkg::EV_BYTE, b, slt_pkg::KIND_OP);
    end else begin
      lx_mode = slt_pkg::MODE_WORD;
      emit(slt_pkg::EV_BYTE, b, slt_pkg::KIND_WORD);
    end
  endfunction

  function void lex_byte(logic [7:0] b);
    run_len = 0;
    if (b == slt_pkg::CH_NUL) begin
      case (lx_mode)
        slt_pkg::MODE_WORD:  close_token(slt_pkg::KIND_WORD);
        slt_pkg::MODE_QUOTE: close_token(slt_pkg::KIND_QUOTED);
        slt_pkg::MODE_OP:    close_token(slt_pkg::KIND_OP);
        default: ;
      endcase
      emit(slt_pkg::EV_LINE, 8'h00, slt_pkg::KIND_WORD);
      lx_mode   = slt_pkg::MODE_IDLE;
      lx_single = 1'b0;
      lx_held   = 8'h00;
      lx_count  = 8'h00;
    end else begin
      case (lx_mode)
        slt_pkg::MODE_WORD: begin
          if (is_blank(b) || is_oper(b)) begin
            close_token(slt_pkg::KIND_WORD);
            start_token(b);
          end else begin
            emit(slt_pkg::EV_BYTE, b, slt_pkg::KIND_WORD);
          end
        end
        slt_pkg::MODE_QUOTE: begin
          if (b == (lx_single ? slt_pkg::CH_SQ : slt_pkg::CH_DQ))
            close_token(slt_pkg::KIND_QUOTED);
          else emit(slt_pkg::EV_BYTE, b, slt_pkg::KIND_QUOTED);
        end
        slt_pkg::MODE_OP: begin
          if (b == lx_held) begin
            emit(slt_pkg::EV_BYTE, b, slt_pkg::KIND_OP);
            close_token(slt_pkg::KIND_OP);
          end else begin
            close_token(slt_pkg::KIND_OP);
            start_token(b);
          end
        end
        default: start_token(b);
      endcase
    end
    for (int i = 0; i < run_len; i++) begin
      if (i == run_len - 1) run_buf[i].last_of_run = 1'b1;
      event_q.push_back(run_buf[i]);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    line_valid <= 1'b1;
    line_byte  <= b;
    do @(posedge clk); while (!line_ready);
    lex_byte(b);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    line_valid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0)
      return ($urandom_range(0, 1) != 0) ? slt_pkg::CH_SQ : slt_pkg::CH_DQ;
    do c = 8'($urandom_range(1, 255)); while (is_blank(c) || is_oper(c));
    return c;
  endfunction

  function automatic logic [7:0] oper_char();
    case ($urandom_range(0, 3))
      0:       return slt_pkg::CH_AMP;
      1:       return slt_pkg::CH_PIPE;
      2:       return slt_pkg::CH_LT;
      default: return slt_pkg::CH_GT;
    endcase
  endfunction

  task automatic send_blanks();
    int r;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 5);
      send_byte((r == 5) ? slt_pkg::CH_SPACE : slt_pkg::CH_TAB + r[7:0]);
    end
  endtask

  task automatic send_random_line();
    int         ntok;
    logic [7:0] q;
    logic [7:0] c;
    ntok = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) send_blanks();
    for (int k = 0; k < ntok; k++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          repeat ($urandom_range(1, 6)) send_byte(word_char());
        end
        2: begin
          q = ($urandom_range(0, 1) != 0) ? slt_pkg::CH_SQ : slt_pkg::CH_DQ;
          send_byte(q);
          repeat ($urandom_range(0, 5)) begin
            do c = 8'($urandom_range(1, 255)); while (c == q);
            send_byte(c);
          end
          if (k != ntok - 1 || $urandom_range(0, 3) != 0) send_byte(q);
        end
        default: begin
          c = oper_char();
          send_byte(c);
          if ($urandom_range(0, 1) != 0) send_byte(c);
        end
      endcase
      if ($urandom_range(0, 3) != 0) send_blanks();
    end
    send_byte(slt_pkg::CH_NUL);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    send_text("a\"b\t\"\" &&|<>");
    send_byte(8'hff);
    send_byte(8'h01);
    send_text("\r'x\"");
    send_byte(slt_pkg::CH_NUL);
    send_text(">");
    send_byte(slt_pkg::CH_NUL);
    send_byte(slt_pkg::CH_NUL);
    send_text("<''x");
    send_byte(slt_pkg::CH_NUL);
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (3) send_random_line();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_req++;
    line_valid <= 1'b0;
    while (hold_ack != hold_req) @(posedge clk);
    tx_idle_en = 1'b0;
    send_text("cat <<in >>out||x&&y");
    send_byte(slt_pkg::CH_NUL);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_random_line();
    wait_drained();
    send_random_line();
  endtask

  task automatic test_count_saturation();
    repeat (SAT_PAIRS) send_text("<>");
    send_byte(slt_pkg::CH_NUL);
  endtask

  task automatic test_random_lines();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_line();
    end
  endtask

  initial begin
    int v_len;
    bit v_rdy;
    int r;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        v_rdy    = 1'b0;
        v_len    = RX_HOLD_CYCLES;
      end else if (!rx_idle_en) begin
        v_rdy = 1'b1;
        v_len = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          v_rdy = 1'b1;
          v_len = $urandom_range(1, 6);
        end else begin
          v_rdy = 1'b0;
          v_len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
      event_ready <= v_rdy;
      repeat (v_len - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && event_valid && event_ready) begin
      if (event_q.size() == 0) begin
        $error("unexpected event transaction: event_kind %0d out_byte %0d",
               event_kind, out_byte);
        errors++;
      end else begin
        exp_head = event_q.pop_front();
        if (event_kind !== exp_head.event_kind) begin
          $error("event_kind: expected %0d, actual %0d", exp_head.event_kind, event_kind);
          errors++;
        end
        if (out_byte !== exp_head.out_byte) begin
          $error("out_byte: expected %0d, actual %0d", exp_head.out_byte, out_byte);
          errors++;
        end
        if (token_kind !== exp_head.token_kind) begin
          $error("token_kind: expected %0d, actual %0d", exp_head.token_kind, token_kind);
          errors++;
        end
        if (token_count !== exp_head.token_count) begin
          $error("token_count: expected %0d, actual %0d",
                 exp_head.token_count, token_count);
          errors++;
        end
        if (last_of_run !== exp_head.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d",
                 exp_head.last_of_run, last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (line_valid && line_ready) || (event_valid && event_ready)) begin
      stuck <= 0;
    end else if (stuck + 1 >= WATCHDOG_CYCLES) begin
      $display("shell_line_tokenizer regression: fail");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_rate();
    test_backpressure();
    test_sender_pause();
    test_count_saturation();
    test_random_lines();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0 && event_q.size() == 0) begin
      $display("shell_line_tokenizer regression: pass");
    end else begin
      $display("shell_line_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
